/* design/srt_pkg.sv */
// Shared constants, types and helpers for the segment rigid transform block.
// Used by the channel interfaces and every module of the block; no dependencies.
package srt_pkg;

    // Number formats
    localparam int CORDIC_STAGES   = 24;
    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = 32;
    localparam int ANGLE_W         = 30;
    localparam int ROT_W           = 31;
    localparam int Z_W             = 33;
    localparam int CS_W            = 32;
    localparam int CX_W            = 34;
    localparam int NUM_POINTS_C    = 6;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    // Pipeline depths
    localparam int CORDIC_LAT = CORDIC_STAGES + 1;
    localparam int DIV_STAGES = COORD_W;
    localparam int DIV_LAT    = DIV_STAGES + 2;
    localparam int POINT_LAT  = 2;

    localparam logic signed [Z_W-1:0]  PI_Q      = 33'sd843314857;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q = 33'sd421657428;
    localparam logic signed [CX_W-1:0] GAIN_Q30  = 34'sd652032874;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // Arctangent of 2^-i in 2^-28 radian units, rounded.
    localparam logic [31:0] ATAN_TAB [0:29] = '{
        32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290, 32'd16755422,
        32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571, 32'd524287,
        32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
        32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
        32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHIFT_X  = 2'd0,
        REG_SHIFT_Y  = 2'd1,
        REG_ROTATION = 2'd2
    } cfg_index_t;

    typedef logic [NUM_POINTS_C-1:0][COORD_W-1:0] coords_t;

    // One segment as it travels down the pipeline.
    typedef struct packed {
        coords_t             pts;
        logic [ANGLE_W-1:0]  slope;
        logic                clip;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic               clip;
    } sat_t;

    // Clip a wide signed value into the 32-bit coordinate range.
    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > 64'(COORD_MAX))
        begin
            r.val  = COORD_MAX;
            r.clip = 1'b1;
        end
        else if (v < 64'(COORD_MIN))
        begin
            r.val  = COORD_MIN;
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = v[COORD_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

/* design/srt_channels.sv */
// Valid/ready channel interfaces for segment beats and result beats.
// Depends on srt_pkg for field widths.
interface srt_seg_in_if;
    import srt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  mid_x_in;
    logic signed [COORD_W-1:0]  mid_y_in;
    logic signed [COORD_W-1:0]  end_a_x_in;
    logic signed [COORD_W-1:0]  end_a_y_in;
    logic signed [COORD_W-1:0]  end_b_x_in;
    logic signed [COORD_W-1:0]  end_b_y_in;
    logic [ANGLE_W-1:0]         slope_in;
    logic                       last_in;

    modport source (output valid, mid_x_in, mid_y_in, end_a_x_in, end_a_y_in,
                    end_b_x_in, end_b_y_in, slope_in, last_in, input ready);
    modport sink (input valid, mid_x_in, mid_y_in, end_a_x_in, end_a_y_in,
                  end_b_x_in, end_b_y_in, slope_in, last_in, output ready);
endinterface

interface srt_seg_out_if;
    import srt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  mid_x_out;
    logic signed [COORD_W-1:0]  mid_y_out;
    logic signed [COORD_W-1:0]  end_a_x_out;
    logic signed [COORD_W-1:0]  end_a_y_out;
    logic signed [COORD_W-1:0]  end_b_x_out;
    logic signed [COORD_W-1:0]  end_b_y_out;
    logic [ANGLE_W-1:0]         slope_out;
    logic signed [COORD_W-1:0]  gradient;
    logic signed [COORD_W-1:0]  intercept;
    logic                       saturated;
    logic                       last_out;

    modport source (output valid, mid_x_out, mid_y_out, end_a_x_out, end_a_y_out,
                    end_b_x_out, end_b_y_out, slope_out, gradient, intercept,
                    saturated, last_out, input ready);
    modport sink (input valid, mid_x_out, mid_y_out, end_a_x_out, end_a_y_out,
                  end_b_x_out, end_b_y_out, slope_out, gradient, intercept,
                  saturated, last_out, output ready);
endinterface

/* design/srt_cordic.sv */
// Pipelined rotation-mode CORDIC: angle in, cosine and sine (Q30) out.
// One fold stage plus one stage per iteration; depends on srt_pkg.
module srt_cordic (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [srt_pkg::Z_W-1:0]  angle,
    output logic signed [srt_pkg::CS_W-1:0] cos_q,
    output logic signed [srt_pkg::CS_W-1:0] sin_q
);
    import srt_pkg::*;

    logic signed [CX_W-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [CX_W-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]  z_reg [0:CORDIC_STAGES];
    logic                   neg_reg [0:CORDIC_STAGES];

    logic signed [Z_W-1:0]  z_next;
    logic                   neg_next;
    logic signed [CX_W-1:0] x_fin;
    logic signed [CX_W-1:0] y_fin;

    // Fold the angle once into minus to plus half pi.
    always_comb
    begin
        z_next   = angle;
        neg_next = 1'b0;
        if (angle > HALF_PI_Q)
        begin
            z_next   = angle - PI_Q;
            neg_next = 1'b1;
        end
        else if (angle < -HALF_PI_Q)
        begin
            z_next   = angle + PI_Q;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_next;
            neg_reg[0] <= neg_next;
        end
    end

    // One micro-rotation per stage, floor shifts.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam logic signed [Z_W-1:0] ATAN_I = Z_W'(ATAN_TAB[i]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
            end
        end
    end

    // Undo the fold by negating both results.
    assign x_fin = neg_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
    assign y_fin = neg_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
    assign cos_q = x_fin[CS_W-1:0];
    assign sin_q = y_fin[CS_W-1:0];

endmodule

/* design/srt_points.sv */
// Rotates the three points of a segment and adds the translation, two stages.
// Depends on srt_pkg for widths and the saturation helper.
module srt_points (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [srt_pkg::CS_W-1:0]    cos_q,
    input  logic signed [srt_pkg::CS_W-1:0]    sin_q,
    input  srt_pkg::coords_t                 pts_in,
    input  logic signed [srt_pkg::COORD_W-1:0] shift_x,
    input  logic signed [srt_pkg::COORD_W-1:0] shift_y,
    output srt_pkg::coords_t                 pts_out,
    output logic                             clip
);
    import srt_pkg::*;

    localparam logic signed [65:0] HALF_ROUND = 66'sd1 <<< 29;

    logic signed [63:0] pc_reg [0:NUM_POINTS_C-1];
    logic signed [63:0] ps_reg [0:NUM_POINTS_C-1];
    coords_t            pts_reg;
    coords_t            pts_next;
    logic               clip_reg;
    logic               clip_next;

    // Stage one: every coordinate times cosine and sine.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NUM_POINTS_C; j++)
            begin
                pc_reg[j] <= 64'(cos_q) * 64'($signed(pts_in[j]));
                ps_reg[j] <= 64'(sin_q) * 64'($signed(pts_in[j]));
            end
        end
    end

    // Stage two: combine, round, translate and clip.
    always_comb
    begin
        logic signed [65:0] acc_x;
        logic signed [65:0] acc_y;
        sat_t               sx;
        sat_t               sy;
        pts_next  = '0;
        clip_next = 1'b0;
        for (int p = 0; p < NUM_POINTS_C / 2; p++)
        begin
            acc_x = 66'(pc_reg[2*p]) - 66'(ps_reg[2*p+1]) + HALF_ROUND;
            acc_y = 66'(ps_reg[2*p]) + 66'(pc_reg[2*p+1]) + HALF_ROUND;
            acc_x = (acc_x >>> 30) + 66'(shift_x);
            acc_y = (acc_y >>> 30) + 66'(shift_y);
            sx = sat32(acc_x[63:0]);
            sy = sat32(acc_y[63:0]);
            pts_next[2*p]   = sx.val;
            pts_next[2*p+1] = sy.val;
            clip_next = clip_next | sx.clip | sy.clip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pts_reg  <= pts_next;
            clip_reg <= clip_next;
        end
    end

    assign pts_out = pts_reg;
    assign clip    = clip_reg;

endmodule

/* design/srt_div.sv */
// Pipelined restoring divider for the gradient sin * 2^F / cos, one bit a stage.
// Truncates toward zero and clips to 32 bits; depends on srt_pkg.
module srt_div (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [srt_pkg::CS_W-1:0]    sin_q,
    input  logic signed [srt_pkg::CS_W-1:0]    cos_q,
    output logic signed [srt_pkg::COORD_W-1:0] grad,
    output logic                             clip
);
    import srt_pkg::*;

    localparam int MAG_W = CS_W + 1;
    localparam int NUM_W = MAG_W + COORD_FRAC_BITS;
    localparam int REM_W = MAG_W + 1;

    logic [MAG_W-1:0]   num_mag;
    logic [NUM_W-1:0]   num;
    logic [MAG_W-1:0]   den_mag;
    logic [REM_W-1:0]   hi_part;

    logic               neg_reg  [0:DIV_STAGES];
    logic               zero_reg [0:DIV_STAGES];
    logic               spos_reg [0:DIV_STAGES];
    logic               ovf_reg  [0:DIV_STAGES];
    logic [MAG_W-1:0]   den_reg  [0:DIV_STAGES];
    logic [REM_W-1:0]   rem_reg  [0:DIV_STAGES];
    logic [COORD_W-1:0] low_reg  [0:DIV_STAGES];
    logic [COORD_W-1:0] q_reg    [0:DIV_STAGES];

    logic signed [COORD_W-1:0] grad_reg;
    logic signed [COORD_W-1:0] grad_next;
    logic                      clip_reg;
    logic                      clip_next;

    // Magnitudes and the overflow check on the upper numerator bits.
    assign num_mag = sin_q[CS_W-1] ? MAG_W'(-$signed({sin_q[CS_W-1], sin_q}))
                                   : MAG_W'({sin_q[CS_W-1], sin_q});
    assign den_mag = cos_q[CS_W-1] ? MAG_W'(-$signed({cos_q[CS_W-1], cos_q}))
                                   : MAG_W'({cos_q[CS_W-1], cos_q});
    assign num     = {num_mag, {COORD_FRAC_BITS{1'b0}}};
    assign hi_part = REM_W'(num[NUM_W-1:COORD_W]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0]  <= sin_q[CS_W-1] ^ cos_q[CS_W-1];
            zero_reg[0] <= (cos_q == '0);
            spos_reg[0] <= ~sin_q[CS_W-1];
            ovf_reg[0]  <= (hi_part >= REM_W'(den_mag));
            den_reg[0]  <= den_mag;
            rem_reg[0]  <= hi_part;
            low_reg[0]  <= num[COORD_W-1:0];
            q_reg[0]    <= '0;
        end
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_bit
        logic [REM_W-1:0] trial;
        assign trial = {rem_reg[k][REM_W-2:0], low_reg[k][COORD_W-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                spos_reg[k+1] <= spos_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                den_reg[k+1]  <= den_reg[k];
                low_reg[k+1]  <= {low_reg[k][COORD_W-2:0], 1'b0};
                if (trial >= REM_W'(den_reg[k]))
                begin
                    rem_reg[k+1] <= trial - REM_W'(den_reg[k]);
                    q_reg[k+1]   <= {q_reg[k][COORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= trial;
                    q_reg[k+1]   <= {q_reg[k][COORD_W-2:0], 1'b0};
                end
            end
        end
    end

    // Apply the sign and clip; a zero cosine is a vertical line.
    always_comb
    begin
        logic [COORD_W-1:0] q;
        q         = q_reg[DIV_STAGES];
        grad_next = '0;
        clip_next = 1'b0;
        if (zero_reg[DIV_STAGES])
        begin
            grad_next = spos_reg[DIV_STAGES] ? COORD_MAX : COORD_MIN;
            clip_next = 1'b1;
        end
        else if (ovf_reg[DIV_STAGES])
        begin
            grad_next = neg_reg[DIV_STAGES] ? COORD_MIN : COORD_MAX;
            clip_next = 1'b1;
        end
        else if (!neg_reg[DIV_STAGES])
        begin
            if (q[COORD_W-1])
            begin
                grad_next = COORD_MAX;
                clip_next = 1'b1;
            end
            else
            begin
                grad_next = $signed(q);
            end
        end
        else
        begin
            if (q[COORD_W-1] && (q[COORD_W-2:0] != '0))
            begin
                grad_next = COORD_MIN;
                clip_next = 1'b1;
            end
            else
            begin
                grad_next = $signed(-q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grad_reg <= grad_next;
            clip_reg <= clip_next;
        end
    end

    assign grad = grad_reg;
    assign clip = clip_reg;

endmodule

/* design/segment_rigid_transform_top.sv */
// Segment rigid transform: rotates, translates and re-slopes one line segment
// per beat. Depends on srt_pkg, the channel interfaces, srt_cordic, srt_points
// and srt_div.
//
// Usage: segment beats enter on seg_in and result beats leave on seg_out, both
// valid/ready channels; a beat moves when valid and ready are high together.
// The configuration port writes shift_x, shift_y or rotation on any clock edge
// with cfg_we high; write it only while no segment is in flight.
// From the input stage, a segment passes through the two parallel CORDIC
// pipelines (one fold stage and 24 iterations), then the pipelined restoring
// gradient divider (one quotient bit per stage), and last the intercept
// multiply and the output register that makes its result valid.
// Throughput is one segment per cycle; the pipeline is fully stalled only while
// a result sits in the output register and seg_out.ready is low, and empty
// stages keep filling while the output register is empty.
// Reset clears all valid bits and the configuration registers to zero; no
// segment is lost or repeated under any stall pattern.
module segment_rigid_transform_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [srt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srt_pkg::CFG_DATA_W-1:0]    cfg_data,
    srt_seg_in_if.sink                        seg_in,
    srt_seg_out_if.source                     seg_out
);
    import srt_pkg::*;

    typedef struct packed {
        logic [ANGLE_W-1:0] slope;
        logic               clip;
        logic               last;
    } tail_t;

    logic signed [COORD_W-1:0] shift_x_reg;
    logic signed [COORD_W-1:0] shift_y_reg;
    logic signed [ROT_W-1:0]   rotation_reg;

    logic                      en;
    logic                      out_valid_reg;

    item_t                     item_reg;
    item_t                     item_next;
    logic                      v0_reg;

    item_t                     dly1_reg [0:CORDIC_LAT-1];
    logic                      vd1_reg  [0:CORDIC_LAT-1];
    tail_t                     dly2_reg [0:DIV_LAT-1];
    logic                      vd2_reg  [0:DIV_LAT-1];
    coords_t                   pd_reg   [0:DIV_LAT-POINT_LAT-1];
    logic                      pclip_reg [0:DIV_LAT-POINT_LAT-1];

    logic signed [CS_W-1:0]    cos_rot;
    logic signed [CS_W-1:0]    sin_rot;
    logic signed [CS_W-1:0]    cos_t;
    logic signed [CS_W-1:0]    sin_t;
    logic signed [Z_W-1:0]     rot_angle;
    logic signed [Z_W-1:0]     t_angle;
    coords_t                   pts_rot;
    logic                      pts_clip;
    logic signed [COORD_W-1:0] grad;
    logic                      grad_clip;
    tail_t                     tail_in;

    // Intercept stage and output register.
    logic signed [63:0]        prod_reg;
    coords_t                   ia_pts_reg;
    logic signed [COORD_W-1:0] ia_grad_reg;
    tail_t                     ia_tail_reg;
    logic                      ia_valid_reg;
    coords_t                   o_pts_reg;
    logic signed [COORD_W-1:0] o_grad_reg;
    logic signed [COORD_W-1:0] o_icpt_reg;
    tail_t                     o_tail_reg;
    sat_t                      icpt_sat;

    // Whole pipeline moves unless a result is held at the output.
    assign en           = ~out_valid_reg | seg_out.ready;
    assign seg_in.ready = en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_x_reg  <= '0;
            shift_y_reg  <= '0;
            rotation_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SHIFT_X:  shift_x_reg  <= cfg_data[COORD_W-1:0];
                REG_SHIFT_Y:  shift_y_reg  <= cfg_data[COORD_W-1:0];
                REG_ROTATION: rotation_reg <= cfg_data[ROT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Input stage: capture the points and wrap the new slope into zero to pi.
    always_comb
    begin
        logic signed [Z_W-1:0] t0;
        logic signed [Z_W-1:0] t1;
        t0 = $signed({{(Z_W-ANGLE_W){1'b0}}, seg_in.slope_in}) + Z_W'(rotation_reg);
        if (t0 < 0)
        begin
            t1 = t0 + PI_Q;
        end
        else if (t0 > PI_Q)
        begin
            t1 = t0 - PI_Q;
        end
        else
        begin
            t1 = t0;
        end
        item_next.clip = 1'b0;
        if (t1 < 0)
        begin
            t1 = '0;
            item_next.clip = 1'b1;
        end
        else if (t1 > PI_Q)
        begin
            t1 = PI_Q;
            item_next.clip = 1'b1;
        end
        item_next.slope  = t1[ANGLE_W-1:0];
        item_next.last   = seg_in.last_in;
        item_next.pts[0] = seg_in.mid_x_in;
        item_next.pts[1] = seg_in.mid_y_in;
        item_next.pts[2] = seg_in.end_a_x_in;
        item_next.pts[3] = seg_in.end_a_y_in;
        item_next.pts[4] = seg_in.end_b_x_in;
        item_next.pts[5] = seg_in.end_b_y_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    // Sine and cosine of the rotation and of the new slope.
    assign rot_angle = Z_W'(rotation_reg);
    assign t_angle   = $signed({{(Z_W-ANGLE_W){1'b0}}, item_reg.slope});

    srt_cordic u_cordic_rot (
        .clk   (clk),
        .en    (en),
        .angle (rot_angle),
        .cos_q (cos_rot),
        .sin_q (sin_rot)
    );

    srt_cordic u_cordic_slope (
        .clk   (clk),
        .en    (en),
        .angle (t_angle),
        .cos_q (cos_t),
        .sin_q (sin_t)
    );

    // Segment data waits alongside the CORDIC pipelines.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly1_reg[0] <= item_reg;
            for (int k = 1; k < CORDIC_LAT; k++)
            begin
                dly1_reg[k] <= dly1_reg[k-1];
            end
        end
    end

    srt_points u_points (
        .clk     (clk),
        .en      (en),
        .cos_q   (cos_rot),
        .sin_q   (sin_rot),
        .pts_in  (dly1_reg[CORDIC_LAT-1].pts),
        .shift_x (shift_x_reg),
        .shift_y (shift_y_reg),
        .pts_out (pts_rot),
        .clip    (pts_clip)
    );

    srt_div u_div (
        .clk   (clk),
        .en    (en),
        .sin_q (sin_t),
        .cos_q (cos_t),
        .grad  (grad),
        .clip  (grad_clip)
    );

    // Points and slope data wait for the divider.
    assign tail_in.slope = dly1_reg[CORDIC_LAT-1].slope;
    assign tail_in.clip  = dly1_reg[CORDIC_LAT-1].clip;
    assign tail_in.last  = dly1_reg[CORDIC_LAT-1].last;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly2_reg[0]  <= tail_in;
            pd_reg[0]    <= pts_rot;
            pclip_reg[0] <= pts_clip;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                dly2_reg[k] <= dly2_reg[k-1];
            end
            for (int k = 1; k < DIV_LAT - POINT_LAT; k++)
            begin
                pd_reg[k]    <= pd_reg[k-1];
                pclip_reg[k] <= pclip_reg[k-1];
            end
        end
    end

    // Valid bits follow the same stages as the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            ia_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < CORDIC_LAT; k++)
            begin
                vd1_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_LAT; k++)
            begin
                vd2_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg     <= seg_in.valid;
            vd1_reg[0] <= v0_reg;
            for (int k = 1; k < CORDIC_LAT; k++)
            begin
                vd1_reg[k] <= vd1_reg[k-1];
            end
            vd2_reg[0] <= vd1_reg[CORDIC_LAT-1];
            for (int k = 1; k < DIV_LAT; k++)
            begin
                vd2_reg[k] <= vd2_reg[k-1];
            end
            ia_valid_reg  <= vd2_reg[DIV_LAT-1];
            out_valid_reg <= ia_valid_reg;
        end
    end

    // Intercept: midpoint x times gradient, then round and subtract.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= 64'($signed(pd_reg[DIV_LAT-POINT_LAT-1][0])) * 64'(grad);
            ia_pts_reg  <= pd_reg[DIV_LAT-POINT_LAT-1];
            ia_grad_reg <= grad;
            ia_tail_reg.slope <= dly2_reg[DIV_LAT-1].slope;
            ia_tail_reg.last  <= dly2_reg[DIV_LAT-1].last;
            ia_tail_reg.clip  <= dly2_reg[DIV_LAT-1].clip
                                 | pclip_reg[DIV_LAT-POINT_LAT-1] | grad_clip;
        end
    end

    always_comb
    begin
        logic signed [64:0] rnd;
        logic signed [64:0] diff;
        rnd  = (65'(prod_reg) + (65'sd1 <<< (COORD_FRAC_BITS - 1))) >>> COORD_FRAC_BITS;
        diff = 65'($signed(ia_pts_reg[1])) - rnd;
        icpt_sat = sat32(diff[63:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_pts_reg        <= ia_pts_reg;
            o_grad_reg       <= ia_grad_reg;
            o_icpt_reg       <= icpt_sat.val;
            o_tail_reg.slope <= ia_tail_reg.slope;
            o_tail_reg.last  <= ia_tail_reg.last;
            o_tail_reg.clip  <= ia_tail_reg.clip | icpt_sat.clip;
        end
    end

    // Result beat.
    assign seg_out.valid       = out_valid_reg;
    assign seg_out.mid_x_out   = o_pts_reg[0];
    assign seg_out.mid_y_out   = o_pts_reg[1];
    assign seg_out.end_a_x_out = o_pts_reg[2];
    assign seg_out.end_a_y_out = o_pts_reg[3];
    assign seg_out.end_b_x_out = o_pts_reg[4];
    assign seg_out.end_b_y_out = o_pts_reg[5];
    assign seg_out.slope_out   = o_tail_reg.slope;
    assign seg_out.gradient    = o_grad_reg;
    assign seg_out.intercept   = o_icpt_reg;
    assign seg_out.saturated   = o_tail_reg.clip;
    assign seg_out.last_out    = o_tail_reg.last;

endmodule
